>>> rtl/lkvc_pkg.sv
package lkvc_pkg;

  localparam int ENTRIES_DEF     = 16;
  localparam int KEY_WIDTH_DEF   = 16;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam int IN_KEY_W  = 16;
  localparam int DATA_W    = 32;
  localparam int CAP_W     = 5;
  localparam int PADDR_W   = 3;

  localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
  localparam logic              REG_CAPACITY = 1'b0;
  localparam logic [DATA_W-1:0] MISS_VALUE = '1;

  localparam logic MODE_GET = 1'b0;
  localparam logic MODE_SET = 1'b1;

  typedef struct packed {
    logic                     mode;
    logic [IN_KEY_W-1:0]      key;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic                     hit;
    logic signed [DATA_W-1:0] read_value;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_get;
    logic out_busy;
  } dp_stat_t;

endpackage

>>> rtl/lkvc_regs.sv
module lkvc_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lkvc_pkg::PADDR_W-1:0]  paddr,
  input  logic [lkvc_pkg::DATA_W-1:0]   pwdata,
  output logic [lkvc_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output logic [lkvc_pkg::CAP_W-1:0]    capacity
);
  import lkvc_pkg::*;

  logic [CAP_W-1:0] cap_r;
  logic [CAP_W-1:0] cap_nxt;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    cap_nxt = cap_r;
    if (wr_en && paddr[2] == REG_CAPACITY) begin
      cap_nxt = pwdata[CAP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else begin
      cap_r <= cap_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_CAPACITY) begin
      prdata = {{(DATA_W-CAP_W){1'b0}}, cap_r};
    end
  end

  assign capacity = cap_r;

endmodule

>>> rtl/lkvc_ctrl.sv
module lkvc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lkvc_pkg::dp_stat_t   stat,
  output lkvc_pkg::ctrl_cmd_t  cmd
);
  import lkvc_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!(stat.is_get && stat.out_busy)) begin
          cmd.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/lkvc_dp.sv
module lkvc_dp #(
  parameter int ENTRIES     = lkvc_pkg::ENTRIES_DEF,
  parameter int KEY_WIDTH   = lkvc_pkg::KEY_WIDTH_DEF,
  parameter int VALUE_WIDTH = lkvc_pkg::VALUE_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lkvc_pkg::in_item_t          in_data,
  input  logic [lkvc_pkg::CAP_W-1:0]  capacity,
  input  lkvc_pkg::ctrl_cmd_t         cmd,
  output lkvc_pkg::dp_stat_t          stat,
  output logic                        out_valid,
  input  logic                        out_ready,
  output lkvc_pkg::out_item_t         out_data
);
  import lkvc_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCC_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;
  localparam logic [CMP_W-1:0] ENT_C = CMP_W'(ENTRIES);

  logic                   mode_r;
  logic [KEY_WIDTH-1:0]   key_r;
  logic [VALUE_WIDTH-1:0] value_r;

  logic [KEY_WIDTH-1:0]   keys_r   [ENTRIES];
  logic [VALUE_WIDTH-1:0] values_r [ENTRIES];
  logic [ENTRIES-1:0]     valid_r;
  logic [ENTRIES-1:0]     valid_nxt;
  logic [IDX_W-1:0]       rank_r   [ENTRIES];
  logic [IDX_W-1:0]       rank_nxt [ENTRIES];
  logic [OCC_W-1:0]       occ_r;
  logic [OCC_W-1:0]       occ_nxt;

  logic                   out_valid_r;
  logic                   out_valid_nxt;
  out_item_t              out_r;

  logic [KEY_WIDTH+IN_KEY_W-1:0]    key_ext;
  logic [VALUE_WIDTH+DATA_W-1:0]    val_ext;
  logic [ENTRIES-1:0]     match;
  logic [ENTRIES-1:0]     lru;
  logic                   hit;
  logic [IDX_W-1:0]       hit_idx;
  logic [IDX_W-1:0]       lru_idx;
  logic [IDX_W-1:0]       free_idx;
  logic [IDX_W-1:0]       hit_rank;
  logic [IDX_W-1:0]       occ_m1;
  logic [CMP_W-1:0]       cap_c;
  logic [CMP_W-1:0]       eff_cap;
  logic                   full;
  logic [IDX_W-1:0]       sel_idx;
  logic [IDX_W-1:0]       old_rank;
  logic                   do_touch;
  logic                   do_write;
  logic                   do_key;
  logic                   insert_new;

  assign key_ext = {{KEY_WIDTH{1'b0}}, in_data.key};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r  <= in_data.mode;
      key_r   <= key_ext[KEY_WIDTH-1:0];
      value_r <= in_data.value[VALUE_WIDTH-1:0];
    end
  end

  assign occ_m1 = IDX_W'(occ_r - OCC_W'(1));

  always_comb begin
    hit_idx  = '0;
    lru_idx  = '0;
    free_idx = '0;
    hit_rank = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = valid_r[i] && (keys_r[i] == key_r);
      lru[i]   = valid_r[i] && (rank_r[i] == occ_m1);
      if (match[i]) begin
        hit_idx  = hit_idx | IDX_W'(i);
        hit_rank = hit_rank | rank_r[i];
      end
      if (lru[i]) begin
        lru_idx = lru_idx | IDX_W'(i);
      end
    end
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = IDX_W'(i);
      end
    end
    hit = |match;
  end

  assign cap_c   = CMP_W'(capacity);
  assign eff_cap = (cap_c == '0) ? CMP_W'(1) : ((cap_c > ENT_C) ? ENT_C : cap_c);
  assign full    = CMP_W'(occ_r) >= eff_cap;

  always_comb begin
    sel_idx    = hit_idx;
    old_rank   = hit_rank;
    do_touch   = 1'b0;
    do_write   = 1'b0;
    do_key     = 1'b0;
    insert_new = 1'b0;
    if (cmd.exec) begin
      if (hit) begin
        do_touch = 1'b1;
        do_write = (mode_r == MODE_SET);
      end else if (mode_r == MODE_SET) begin
        do_touch = 1'b1;
        do_write = 1'b1;
        do_key   = 1'b1;
        if (full) begin
          sel_idx  = lru_idx;
          old_rank = occ_m1;
        end else begin
          sel_idx    = free_idx;
          insert_new = 1'b1;
        end
      end
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    occ_nxt   = occ_r;
    for (int i = 0; i < ENTRIES; i++) begin
      rank_nxt[i] = rank_r[i];
      if (do_touch) begin
        if (IDX_W'(i) == sel_idx) begin
          rank_nxt[i] = '0;
        end else if (valid_r[i] && (insert_new || rank_r[i] < old_rank)) begin
          rank_nxt[i] = rank_r[i] + IDX_W'(1);
        end
      end
    end
    if (insert_new) begin
      valid_nxt[sel_idx] = 1'b1;
      occ_nxt            = occ_r + OCC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      occ_r   <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      valid_r <= valid_nxt;
      occ_r   <= occ_nxt;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= rank_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      values_r[sel_idx] <= value_r;
    end
    if (do_key) begin
      keys_r[sel_idx] <= key_r;
    end
  end

  assign val_ext = {{DATA_W{values_r[hit_idx][VALUE_WIDTH-1]}}, values_r[hit_idx]};

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.exec && mode_r == MODE_GET) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && mode_r == MODE_GET) begin
      out_r.hit        <= hit;
      out_r.read_value <= hit ? val_ext[DATA_W-1:0] : MISS_VALUE;
    end
  end

  assign stat.is_get   = (mode_r == MODE_GET);
  assign stat.out_busy = out_valid_r && !out_ready;
  assign out_valid     = out_valid_r;
  assign out_data      = out_r;

endmodule

>>> rtl/lru_key_value_cache_top.sv
// lru key-value cache
// input channel in_valid/in_ready/in_data carries get or set items (mode, key,
// value); result channel out_valid/out_ready/out_data carries one item
// (hit, read_value) per get, nothing for a set.
// capacity is written through the apb-style port at byte address 0 by the user,
// who must do so only while idle; the block does not enforce this. values 0
// and above ENTRIES are clamped to 1 and ENTRIES. an item passes through a
// capture state, then an execute state in which the parallel key compare and
// rank update over the entry registers finish. a get result is written to the
// output register in its execute state and then shown on out_valid.
// the two-state controller accepts a new item only once the last one has executed.
// the output register holds a result while the receiver stalls; the next item
// is still accepted, and a get waits in its execute cycle until the result
// register is free.
// reset clears valid bits, ranks, occupancy and sets capacity to 16; keys and
// values are left as they are.
module lru_key_value_cache_top #(
  parameter int ENTRIES     = lkvc_pkg::ENTRIES_DEF,
  parameter int KEY_WIDTH   = lkvc_pkg::KEY_WIDTH_DEF,
  parameter int VALUE_WIDTH = lkvc_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  lkvc_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output lkvc_pkg::out_item_t           out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lkvc_pkg::PADDR_W-1:0]  paddr,
  input  logic [lkvc_pkg::DATA_W-1:0]   pwdata,
  output logic [lkvc_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import lkvc_pkg::*;

  logic [CAP_W-1:0] capacity;
  ctrl_cmd_t        cmd;
  dp_stat_t         stat;

  lkvc_regs u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .capacity (capacity)
  );

  lkvc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lkvc_dp #(
    .ENTRIES     (ENTRIES),
    .KEY_WIDTH   (KEY_WIDTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .capacity  (capacity),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> bench/lru_kv_checker.sv
module lru_kv_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  lkvc_pkg::in_item_t           in_data,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  lkvc_pkg::out_item_t          out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [lkvc_pkg::PADDR_W-1:0] paddr,
  input  logic [lkvc_pkg::DATA_W-1:0]  pwdata,
  output int                           fail_count,
  output int                           pending_count
);
  import lkvc_pkg::*;

  localparam int ENTRIES = ENTRIES_DEF;
  localparam logic [PADDR_W-1:0] CAP_ADDR = PADDR_W'(4 * int'(REG_CAPACITY));
  localparam int PRINT_LIMIT = 100;

  logic [IN_KEY_W-1:0] slot_key [ENTRIES];
  logic [DATA_W-1:0]   slot_val [ENTRIES];
  bit                  slot_used [ENTRIES];
  int unsigned         slot_age [ENTRIES];
  int unsigned         fill;
  logic [CAP_W-1:0]    cap_reg;
  out_item_t           lookups_due[$];
  int                  errors = 0;
  int                  results_seen = 0;

  assign fail_count = errors;

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    errors++;
    if (errors <= PRINT_LIMIT)
      $display("mismatch at %0t, result %0d: %s got %h want %h",
               $time, results_seen, what, got, want);
  endtask

  function automatic int usable_capacity();
    if (cap_reg == '0) return 1;
    if (cap_reg > ENTRIES) return ENTRIES;
    return int'(cap_reg);
  endfunction

  function automatic int find_slot(logic [IN_KEY_W-1:0] k);
    for (int i = 0; i < ENTRIES; i++)
      if (slot_used[i] && slot_key[i] == k) return i;
    return -1;
  endfunction

  // entries more recent than the old rank age by one
  function automatic void promote(int s, int unsigned old_age);
    for (int i = 0; i < ENTRIES; i++)
      if (i != s && slot_used[i] && slot_age[i] < old_age) slot_age[i]++;
    slot_age[s] = 0;
  endfunction

  function automatic bit cache_access(input in_item_t it, output out_item_t res);
    int s;
    int victim;
    int unsigned oldest;
    s = find_slot(it.key);
    res.hit = 1'b0;
    res.read_value = MISS_VALUE;
    if (it.mode == MODE_GET) begin
      if (s >= 0) begin
        promote(s, slot_age[s]);
        res.hit = 1'b1;
        res.read_value = slot_val[s];
      end
      return 1'b1;
    end
    if (s >= 0) begin
      slot_val[s] = it.value;
      promote(s, slot_age[s]);
      return 1'b0;
    end
    victim = -1;
    oldest = 0;
    if (fill >= usable_capacity()) begin
      for (int i = 0; i < ENTRIES; i++)
        if (slot_used[i] && (victim < 0 || slot_age[i] > oldest)) begin
          victim = i;
          oldest = slot_age[i];
        end
      if (victim >= 0) begin
        slot_key[victim] = it.key;
        slot_val[victim] = it.value;
        promote(victim, oldest);
      end
      return 1'b0;
    end
    for (int i = 0; i < ENTRIES; i++)
      if (!slot_used[i] && victim < 0) victim = i;
    for (int i = 0; i < ENTRIES; i++)
      if (slot_used[i]) slot_age[i]++;
    slot_used[victim] = 1'b1;
    slot_key[victim] = it.key;
    slot_val[victim] = it.value;
    slot_age[victim] = 0;
    fill++;
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    out_item_t res;
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) begin
        slot_used[i] = 1'b0;
        slot_age[i] = 0;
      end
      fill = 0;
      cap_reg = CAP_RESET;
      lookups_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = out_data;
        results_seen++;
        if (lookups_due.size() == 0) begin
          report_mismatch("unexpected result item", DATA_W'(got), '0);
        end else begin
          want = lookups_due.pop_front();
          if (got.hit !== want.hit)
            report_mismatch("hit", DATA_W'(got.hit), DATA_W'(want.hit));
          if (got.read_value !== want.read_value)
            report_mismatch("read_value", got.read_value, want.read_value);
        end
      end
      if (psel && penable && pwrite && pready && paddr == CAP_ADDR)
        cap_reg = pwdata[CAP_W-1:0];
      if (in_valid && in_ready) begin
        if (cache_access(in_data, res)) lookups_due.push_back(res);
      end
    end
    pending_count <= lookups_due.size();
  end

endmodule

>>> bench/tb.sv
module tb;
  import lkvc_pkg::*;

  localparam int HALF_PERIOD   = 2;
  localparam int SETTLE_CYCLES = 6;
  localparam int HOLD_CYCLES   = 400;
  localparam int HOLD_PHASE    = 3;
  localparam int HOLD_AT       = 20;
  localparam int PHASES        = 8;
  localparam int POOL_MAX      = 40;
  localparam int RUN_LIMIT     = 2000000;

  typedef enum int {RX_STEADY, RX_RANDOM, RX_BURSTY} rx_style_e;

  typedef struct {
    logic [CAP_W-1:0] cap;
    int               pool_n;
    int               set_pct;
    int               gap_max;
    rx_style_e        rx;
    int               n_items;
  } phase_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  in_item_t           in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_item_t          out_data;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0]  pwdata = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  int                 fail_count;
  int                 pending_count;
  rx_style_e          rx_style = RX_STEADY;
  logic               hold_req = 1'b0;
  bit                 hold_done = 1'b0;
  int                 burst_left = 0;
  int                 gap_max = 0;
  logic [IN_KEY_W-1:0] key_pool [POOL_MAX];

  localparam logic [PADDR_W-1:0] CAP_ADDR = PADDR_W'(4 * int'(REG_CAPACITY));

  always #HALF_PERIOD clk = ~clk;

  lru_key_value_cache_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  lru_kv_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  function automatic phase_t phase_plan(int idx);
    phase_t ph;
    case (idx)
      0: ph = '{5'd16, 20, 50, 0, RX_STEADY, 100};
      1: ph = '{5'd1, 3, 50, 4, RX_RANDOM, 100};
      2: ph = '{5'd0, 3, 50, 6, RX_BURSTY, 80};
      3: ph = '{5'd31, 24, 55, 3, RX_BURSTY, 150};
      4: ph = '{5'd4, 8, 50, 8, RX_RANDOM, 120};
      5: ph = '{5'd17, 30, 60, 2, RX_BURSTY, 150};
      6: ph = '{5'd8, 12, 45, 5, RX_RANDOM, 120};
      default: ph = '{5'd2, 5, 50, 1, RX_STEADY, 130};
    endcase
    return ph;
  endfunction

  function automatic in_item_t cmd(logic m, logic [IN_KEY_W-1:0] k, logic [DATA_W-1:0] v);
    in_item_t it;
    it.mode = m;
    it.key = k;
    it.value = v;
    return it;
  endfunction

  function automatic in_item_t random_item(int pool_n, int set_pct);
    in_item_t it;
    it.mode = ($urandom_range(0, 99) < set_pct) ? MODE_SET : MODE_GET;
    if ($urandom_range(0, 19) == 0) it.key = IN_KEY_W'($urandom);
    else it.key = key_pool[$urandom_range(0, pool_n - 1)];
    case ($urandom_range(0, 11))
      0: it.value = 32'h7fff_ffff;
      1: it.value = 32'h8000_0000;
      2: it.value = '1;
      3: it.value = '0;
      default: it.value = $urandom;
    endcase
    return it;
  endfunction

  task automatic fill_pool();
    for (int i = 0; i < POOL_MAX; i++) begin
      if ($urandom_range(0, 7) == 0) key_pool[i] = $urandom_range(0, 1) ? '1 : '0;
      else key_pool[i] = IN_KEY_W'($urandom);
    end
  endtask

  task automatic push_item(input in_item_t item);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CAP_ADDR;
    pwdata <= DATA_W'(cap);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic run_directed();
    gap_max = 0;
    burst_left = 0;
    rx_style <= RX_RANDOM;
    // empty cache, extremes of key and value, update of a present key
    push_item(cmd(MODE_GET, 16'h0000, 32'h0000_0000));
    push_item(cmd(MODE_SET, 16'h0000, 32'h7fff_ffff));
    push_item(cmd(MODE_SET, 16'hffff, 32'h8000_0000));
    push_item(cmd(MODE_GET, 16'h0000, 32'h0000_0000));
    push_item(cmd(MODE_GET, 16'hffff, 32'hffff_ffff));
    push_item(cmd(MODE_SET, 16'h0000, 32'hffff_ffff));
    push_item(cmd(MODE_GET, 16'h0000, 32'h1234_5678));
    push_item(cmd(MODE_GET, 16'h5555, 32'haaaa_aaaa));
    drain();
    // eviction order follows recency
    write_capacity(5'd2);
    push_item(cmd(MODE_GET, 16'hffff, 32'h0));
    push_item(cmd(MODE_SET, 16'haaaa, 32'h0000_0001));
    push_item(cmd(MODE_GET, 16'h0000, 32'h0));
    push_item(cmd(MODE_GET, 16'hffff, 32'h0));
    push_item(cmd(MODE_GET, 16'haaaa, 32'h0));
    drain();
    // capacity below occupancy
    write_capacity(5'd1);
    push_item(cmd(MODE_SET, 16'h1234, 32'h1234_5678));
    push_item(cmd(MODE_GET, 16'hffff, 32'h0));
    push_item(cmd(MODE_GET, 16'haaaa, 32'h0));
    push_item(cmd(MODE_GET, 16'h1234, 32'h0));
    drain();
    // zero capacity acts as one
    write_capacity(5'd0);
    push_item(cmd(MODE_SET, 16'h0001, 32'h5555_5555));
    push_item(cmd(MODE_GET, 16'h1234, 32'h0));
    drain();
    // capacity above the entry count
    write_capacity(5'd31);
    push_item(cmd(MODE_SET, 16'h8000, 32'h0000_0000));
    push_item(cmd(MODE_GET, 16'h8000, 32'h0));
    push_item(cmd(MODE_GET, 16'h7fff, 32'h0));
    drain();
  endtask

  initial begin : rx_side
    int run_left;
    bit run_ready;
    run_left = 0;
    run_ready = 1'b1;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      case (rx_style)
        RX_STEADY: out_ready <= 1'b1;
        RX_RANDOM: out_ready <= ($urandom_range(0, 99) < 65);
        default: begin
          if (run_left == 0) begin
            run_ready = !run_ready;
            run_left = $urandom_range(1, 12);
          end
          run_left--;
          out_ready <= run_ready;
        end
      endcase
    end
  end

  initial begin
    #RUN_LIMIT;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    phase_t ph;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    for (int p = 0; p < PHASES; p++) begin
      ph = phase_plan(p);
      write_capacity(ph.cap);
      fill_pool();
      gap_max = ph.gap_max;
      burst_left = 0;
      rx_style <= ph.rx;
      for (int n = 0; n < ph.n_items; n++) begin
        if (p == HOLD_PHASE && n == HOLD_AT) hold_req <= 1'b1;
        push_item(random_item(ph.pool_n, ph.set_pct));
      end
      drain();
    end
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
